### hw/rtl/pcr_pkg.sv
package pcr_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int SAMPLE_W    = 32;
  localparam int LEN_W       = 16;
  localparam int PRE_W       = 10;
  localparam int CFG_IDX_W   = 1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [2:0]          status_t;
  typedef logic [SAMPLE_W-1:0] word_t;

  localparam status_t ST_STORED   = 3'd0;
  localparam status_t ST_COMPLETE = 3'd1;
  localparam status_t ST_TOO_LONG = 3'd2;
  localparam status_t ST_DISCARD  = 3'd3;
  localparam status_t ST_READ     = 3'd4;
  localparam status_t ST_RD_LONG  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_RISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_FALL = 1'd1;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

endpackage

### hw/rtl/pcr_ram.sv
module pcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pretrigger_capture_ring_core.sv
// An accepted item passes the item stage, then the output register.
// Throughput: one item per cycle, push or read, while out_ready takes results.
// A stored push uses the ring RAM write port, a read its registered read port.
// One result may wait at the output while a further item is taken in.
// Reset (synchronous, active low) clears pointers, flags, pre-trigger counts
// and valids at once; ring contents stay undefined until written.
module pretrigger_capture_ring_core #(
  parameter int SAMPLE_BITS = pcr_pkg::SAMPLE_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic                         in_first_of_block,
  input  logic [15:0]                  in_block_length,
  input  logic                         in_event_flag,
  input  logic                         in_rising_event,
  input  logic [9:0]                   in_read_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pcr_pkg::status_t             out_status,
  output logic [SAMPLE_BITS-1:0]       out_read_data,
  output logic [9:0]                   out_stop_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcr_pkg::PRE_W-1:0]     cfg_wdata
);
  import pcr_pkg::*;

  localparam idx_t IDX_LAST = IDX_W'(RING_DEPTH - 1);

  idx_t             wr_idx_r, wr_idx_nxt;
  idx_t             end_idx_r, end_idx_nxt;
  idx_t             stop_r, stop_nxt;
  idx_t             rd_idx_r, rd_idx_nxt;
  logic             armed_r, armed_nxt;
  logic             disc_r, disc_nxt;
  logic [PRE_W-1:0] pre_rise_r, pre_fall_r;

  logic             a_valid_r;
  status_t          a_status_r;
  idx_t             a_stop_r;
  logic             a_read_r;
  logic             o_valid_r;
  status_t          o_status_r;
  logic [SAMPLE_BITS-1:0] o_data_r;
  idx_t             o_stop_r;

  logic             acc, a_move;
  status_t          st;
  logic             ram_we, ram_re;
  idx_t             rd_addr;
  idx_t             stop_calc, stop_eff;
  logic             armed_eff;
  logic             too_long;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign a_move    = a_valid_r && (!o_valid_r || out_ready);
  assign in_ready  = !a_valid_r || a_move;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign too_long  = in_block_length > LEN_W'(RING_DEPTH);

  assign stop_calc = end_idx_r - IDX_W'(in_rising_event ? pre_rise_r : pre_fall_r);
  assign armed_eff = armed_r || in_event_flag;
  assign stop_eff  = (in_event_flag && !armed_r) ? stop_calc : stop_r;

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    end_idx_nxt = end_idx_r;
    stop_nxt    = stop_r;
    rd_idx_nxt  = rd_idx_r;
    armed_nxt   = armed_r;
    disc_nxt    = disc_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    rd_addr     = rd_idx_r;
    st          = ST_STORED;
    if (in_kind == KIND_PUSH) begin
      if (in_first_of_block) begin
        disc_nxt = 1'b0;
        if (too_long) begin
          disc_nxt = 1'b1;
          st       = ST_TOO_LONG;
        end else if (armed_eff && end_idx_r == stop_eff) begin
          stop_nxt  = stop_eff;
          armed_nxt = 1'b0;
          disc_nxt  = 1'b1;
          st        = ST_COMPLETE;
        end else begin
          stop_nxt  = stop_eff;
          armed_nxt = armed_eff;
        end
      end else if (disc_r) begin
        st = ST_DISCARD;
      end
      if (st == ST_STORED) begin
        ram_we      = acc;
        wr_idx_nxt  = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
        end_idx_nxt = wr_idx_nxt;
      end
    end else begin
      st = ST_READ;
      if (in_first_of_block) begin
        end_idx_nxt = '0;
        rd_addr     = IDX_W'(in_read_offset);
        disc_nxt    = 1'b0;
        if (too_long) begin
          disc_nxt = 1'b1;
          st       = ST_RD_LONG;
        end
      end else if (disc_r) begin
        st = ST_DISCARD;
      end
      rd_idx_nxt = rd_addr;
      if (st == ST_READ) begin
        ram_re     = acc;
        rd_idx_nxt = (rd_addr == IDX_LAST) ? '0 : rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      end_idx_r  <= '0;
      stop_r     <= '0;
      rd_idx_r   <= '0;
      armed_r    <= 1'b0;
      disc_r     <= 1'b0;
      pre_rise_r <= '0;
      pre_fall_r <= '0;
    end else begin
      if (acc) begin
        wr_idx_r  <= wr_idx_nxt;
        end_idx_r <= end_idx_nxt;
        stop_r    <= stop_nxt;
        rd_idx_r  <= rd_idx_nxt;
        armed_r   <= armed_nxt;
        disc_r    <= disc_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRE_RISE: pre_rise_r <= cfg_wdata;
          REG_PRE_FALL: pre_fall_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item stage alongside the RAM read, then output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_status_r <= st;
      a_stop_r   <= stop_nxt;
      a_read_r   <= (st == ST_READ);
    end
    if (a_move) begin
      o_status_r <= a_status_r;
      o_stop_r   <= a_stop_r;
      o_data_r   <= a_read_r ? ram_rdata : '0;
    end
  end

  pcr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(in_sample),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign out_valid      = o_valid_r;
  assign out_status     = o_status_r;
  assign out_read_data  = o_data_r;
  assign out_stop_index = 10'(o_stop_r);

endmodule

### hw/rtl/pcr_checker.sv
module pcr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input pcr_pkg::status_t out_status,
  input logic [31:0]      out_read_data
);
  import pcr_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_STORED || out_status == ST_COMPLETE ||
                   out_status == ST_TOO_LONG || out_status == ST_DISCARD ||
                   out_status == ST_READ || out_status == ST_RD_LONG))
    else $error("unknown status code");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_READ |-> out_read_data == '0)
    else $error("read data on a non-read item");

endmodule

bind pretrigger_capture_ring_core pcr_checker u_pcr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_read_data(out_read_data)
);
